@@ rtl/snts_pkg.sv @@
`timescale 1ns / 1ps
// types and codes shared by the sigmoid neuron train step block
// no dependencies

package snts_pkg;

   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE = 1'd1;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_FWD  = 2'd1;
   localparam logic [1:0] OP_BWD  = 2'd2;
   localparam logic [1:0] OP_UPD  = 2'd3;

   localparam logic [1:0] KIND_ACT  = 2'd0;
   localparam logic [1:0] KIND_GRAD = 2'd1;
   localparam logic [1:0] KIND_UPD  = 2'd2;

   localparam logic [15:0] GAIN_RESET       = 16'd4096;
   localparam logic [14:0] LEARN_RATE_RESET = 15'd410;

   localparam logic [2:0] MUL_FWD = 3'd0;
   localparam logic [2:0] MUL_GLO = 3'd1;
   localparam logic [2:0] MUL_GHI = 3'd2;
   localparam logic [2:0] MUL_BWD = 3'd3;
   localparam logic [2:0] MUL_PR  = 3'd4;
   localparam logic [2:0] MUL_SP  = 3'd5;
   localparam logic [2:0] MUL_LT  = 3'd6;
   localparam logic [2:0] MUL_TA  = 3'd7;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [3:0]         index;
      logic signed [15:0] value;
      logic signed [15:0] out_weight;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] result_value;
      logic signed [15:0] delta;
      logic [3:0]         slot;
   } rsp_type;

   typedef struct packed {
      logic       take;
      logic       wr_load;
      logic       wr_act;
      logic       mul_en;
      logic [2:0] mul_sel;
      logic       acc_fwd;
      logic       acc_bwd;
      logic       lo_save;
      logic       z_load;
      logic       s_load;
      logic       p_load;
      logic       t_load;
      logic       emit_act;
      logic       emit_grad;
      logic       emit_upd;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic rsp_free;
   } status_type;

endpackage

@@ rtl/snts_ram.sv @@
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module snts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/snts_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer for the sigmoid neuron train step
// depends on snts_pkg

module snts_ctrl import snts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_LOAD = 5'd1;
   localparam logic [4:0] ST_FMUL = 5'd2;
   localparam logic [4:0] ST_FACC = 5'd3;
   localparam logic [4:0] ST_G0   = 5'd4;
   localparam logic [4:0] ST_G1   = 5'd5;
   localparam logic [4:0] ST_GSUM = 5'd6;
   localparam logic [4:0] ST_FOUT = 5'd7;
   localparam logic [4:0] ST_BMUL = 5'd8;
   localparam logic [4:0] ST_BACC = 5'd9;
   localparam logic [4:0] ST_BP   = 5'd10;
   localparam logic [4:0] ST_BPR  = 5'd11;
   localparam logic [4:0] ST_BD   = 5'd12;
   localparam logic [4:0] ST_BOUT = 5'd13;
   localparam logic [4:0] ST_U0   = 5'd14;
   localparam logic [4:0] ST_U1   = 5'd15;
   localparam logic [4:0] ST_U2   = 5'd16;
   localparam logic [4:0] ST_UOUT = 5'd17;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               case (req_opcode)
                  OP_LOAD: state_in = ST_LOAD;
                  OP_FWD:  state_in = ST_FMUL;
                  OP_BWD:  state_in = ST_BMUL;
                  OP_UPD:  state_in = ST_U0;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.wr_load = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_FMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_FWD;
            cmd.wr_act  = 1'b1;
            state_in    = ST_FACC;
         end
         ST_FACC: begin
            cmd.acc_fwd = 1'b1;
            state_in    = status.last ? ST_G0 : ST_IDLE;
         end
         ST_G0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GLO;
            state_in    = ST_G1;
         end
         ST_G1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GHI;
            cmd.lo_save = 1'b1;
            state_in    = ST_GSUM;
         end
         ST_GSUM: begin
            cmd.z_load = 1'b1;
            state_in   = ST_FOUT;
         end
         ST_FOUT: begin
            if (status.rsp_free) begin
               cmd.emit_act = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_BMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_BWD;
            state_in    = ST_BACC;
         end
         ST_BACC: begin
            cmd.acc_bwd = 1'b1;
            state_in    = status.last ? ST_BP : ST_IDLE;
         end
         ST_BP: begin
            cmd.s_load  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PR;
            state_in    = ST_BPR;
         end
         ST_BPR: begin
            cmd.p_load = 1'b1;
            state_in   = ST_BD;
         end
         ST_BD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SP;
            state_in    = ST_BOUT;
         end
         ST_BOUT: begin
            if (status.rsp_free) begin
               cmd.emit_grad = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_U0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LT;
            state_in    = ST_U1;
         end
         ST_U1: begin
            cmd.t_load = 1'b1;
            state_in   = ST_U2;
         end
         ST_U2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_TA;
            state_in    = ST_UOUT;
         end
         ST_UOUT: begin
            if (status.rsp_free) begin
               cmd.emit_upd = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/snts_dp.sv @@
`timescale 1ns / 1ps
// datapath: weight and activation stores, shared multiplier, accumulators,
// sigmoid table, csr registers and result register; depends on snts_pkg, snts_ram

module snts_dp import snts_pkg::*; #(
   parameter int FANIN           = 16,
   parameter int SIG_TABLE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   localparam int AW  = (FANIN > 1) ? $clog2(FANIN) : 1;
   localparam int TIW = $clog2(SIG_TABLE_DEPTH);
   localparam longint ONE_Q30 = 64'sd1 << 30;

   // sigmoid sample at left edge of interval k, evaluated at elaboration
   function automatic logic [12:0] sig_entry(input int k);
      longint num;
      longint a;
      longint u;
      longint term;
      longint e;
      longint nn;
      longint dd;
      longint q;
      int     i;
      num  = 16 * longint'(k) - 8 * longint'(SIG_TABLE_DEPTH);
      a    = (num < 0) ? -num : num;
      u    = ((a << 30) / SIG_TABLE_DEPTH) >> 4;
      term = ONE_Q30;
      e    = ONE_Q30;
      term = ((term * u) >> 30) / 1;  e = e - term;
      term = ((term * u) >> 30) / 2;  e = e + term;
      term = ((term * u) >> 30) / 3;  e = e - term;
      term = ((term * u) >> 30) / 4;  e = e + term;
      term = ((term * u) >> 30) / 5;  e = e - term;
      term = ((term * u) >> 30) / 6;  e = e + term;
      term = ((term * u) >> 30) / 7;  e = e - term;
      term = ((term * u) >> 30) / 8;  e = e + term;
      term = ((term * u) >> 30) / 9;  e = e - term;
      term = ((term * u) >> 30) / 10; e = e + term;
      term = ((term * u) >> 30) / 11; e = e - term;
      term = ((term * u) >> 30) / 12; e = e + term;
      term = ((term * u) >> 30) / 13; e = e - term;
      term = ((term * u) >> 30) / 14; e = e + term;
      term = ((term * u) >> 30) / 15; e = e - term;
      term = ((term * u) >> 30) / 16; e = e + term;
      for (i = 0; i < 4; i++) begin
         e = (e * e + (64'sd1 << 29)) >> 30;
      end
      // restoring division, quotient never exceeds 2048
      nn = 8192 * e + ONE_Q30 + e;
      dd = 2 * (ONE_Q30 + e);
      q  = 0;
      for (i = 12; i >= 0; i--) begin
         if (nn >= (dd << i)) begin
            nn = nn - (dd << i);
            q  = q + (64'sd1 << i);
         end
      end
      if (num <= 0) begin
         return q[12:0];
      end
      return 13'(4096 - q);
   endfunction

   function automatic logic signed [15:0] sat16w(input logic signed [56:0] v);
      if (v > 57'sd32767) begin
         return 16'sh7fff;
      end
      if (v < -57'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // round half up by 2^12, then saturate
   function automatic logic signed [15:0] rs16(input logic signed [40:0] v);
      logic signed [40:0] r;
      r = (v + 41'sd2048) >>> 12;
      return sat16w({{16{r[40]}}, r});
   endfunction

   function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
      if (v[40] != v[39]) begin
         return v[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      end
      return v[39:0];
   endfunction

   // registers
   req_type            req_ff, req_in;
   logic signed [15:0] gain_ff, gain_in;
   logic [14:0]        lr_ff, lr_in;
   logic signed [39:0] facc_ff, facc_in;
   logic signed [39:0] bacc_ff, bacc_in;
   logic signed [15:0] oact_ff, oact_in;
   logic signed [15:0] lgrad_ff, lgrad_in;
   logic signed [39:0] prod_ff, prod_in;
   logic signed [39:0] part_ff, part_in;
   logic signed [15:0] z_ff, z_in;
   logic signed [15:0] s_ff, s_in;
   logic signed [19:0] p_ff, p_in;
   logic signed [15:0] t_ff, t_in;
   logic               wok_ff, wok_in;
   logic               aok_ff, aok_in;
   logic [FANIN-1:0]   wvld_ff, wvld_in;
   logic [FANIN-1:0]   avld_ff, avld_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // store access
   logic               in_ok;
   logic               cur_ok;
   logic [AW-1:0]      in_addr;
   logic [AW-1:0]      cur_addr;
   logic [15:0]        w_ram;
   logic [15:0]        a_ram;
   logic signed [15:0] w_rd;
   logic signed [15:0] a_rd;
   logic               w_we;
   logic [15:0]        w_wd;
   logic               a_we;

   // arithmetic
   logic signed [17:0] mul_a;
   logic signed [21:0] mul_b;
   logic signed [39:0] mul_p;
   logic signed [56:0] zsum;
   logic signed [56:0] zr;
   logic signed [40:0] pr;
   logic signed [15:0] prod_rs;
   logic signed [16:0] nsum;
   logic signed [15:0] new_w;
   logic [15:0]        zu;
   logic [16+TIW:0]    tprod;
   logic [TIW-1:0]     ti;
   logic signed [15:0] sig_val;
   logic [12:0]        sig_rom [SIG_TABLE_DEPTH];

   for (genvar k = 0; k < SIG_TABLE_DEPTH; k++) begin : g_sig
      assign sig_rom[k] = sig_entry(k);
   end

   assign in_ok    = 32'(req_data.index) < FANIN;
   assign cur_ok   = 32'(req_ff.index) < FANIN;
   assign in_addr  = AW'(req_data.index);
   assign cur_addr = AW'(req_ff.index);

   assign w_rd = wok_ff ? $signed(w_ram) : 16'sd0;
   assign a_rd = aok_ff ? $signed(a_ram) : 16'sd0;

   assign w_we = (cmd.wr_load || cmd.emit_upd) && cur_ok;
   assign w_wd = cmd.emit_upd ? new_w : req_ff.value;
   assign a_we = cmd.wr_act && cur_ok;

   snts_ram #(
      .WIDTH (16),
      .DEPTH (FANIN)
   ) u_wram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (cur_addr),
      .wr_data (w_wd),
      .rd_en   (cmd.take),
      .rd_addr (in_addr),
      .rd_data (w_ram)
   );

   snts_ram #(
      .WIDTH (16),
      .DEPTH (FANIN)
   ) u_aram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (cur_addr),
      .wr_data (req_ff.value),
      .rd_en   (cmd.take),
      .rd_addr (in_addr),
      .rd_data (a_ram)
   );

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_FWD: begin
            mul_a = {{2{req_ff.value[15]}}, req_ff.value};
            mul_b = {{6{w_rd[15]}}, w_rd};
         end
         MUL_GLO: begin
            mul_a = {{2{gain_ff[15]}}, gain_ff};
            mul_b = {2'b00, facc_ff[19:0]};
         end
         MUL_GHI: begin
            mul_a = {{2{gain_ff[15]}}, gain_ff};
            mul_b = {{2{facc_ff[39]}}, facc_ff[39:20]};
         end
         MUL_BWD: begin
            mul_a = {{2{req_ff.value[15]}}, req_ff.value};
            mul_b = {{6{req_ff.out_weight[15]}}, req_ff.out_weight};
         end
         MUL_PR: begin
            mul_a = 18'sd4096 - {{2{oact_ff[15]}}, oact_ff};
            mul_b = {{6{oact_ff[15]}}, oact_ff};
         end
         MUL_SP: begin
            mul_a = {{2{s_ff[15]}}, s_ff};
            mul_b = {{2{p_ff[19]}}, p_ff};
         end
         MUL_LT: begin
            mul_a = {3'b000, lr_ff};
            mul_b = {{6{lgrad_ff[15]}}, lgrad_ff};
         end
         MUL_TA: begin
            mul_a = {{2{t_ff[15]}}, t_ff};
            mul_b = {{6{a_rd[15]}}, a_rd};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // gain times accumulator from two partial products
   assign zsum = ({{17{prod_ff[39]}}, prod_ff} <<< 20) + {{17{part_ff[39]}}, part_ff};
   assign zr   = (zsum + 57'sd8388608) >>> 24;

   assign pr      = ({prod_ff[39], prod_ff} + 41'sd2048) >>> 12;
   assign prod_rs = rs16({prod_ff[39], prod_ff});

   assign nsum  = {w_rd[15], w_rd} + {prod_rs[15], prod_rs};
   assign new_w = (nsum[16] != nsum[15]) ? (nsum[16] ? 16'sh8000 : 16'sh7fff) : nsum[15:0];

   // table index ((z + 32768) * depth) >> 16
   assign zu      = {~z_ff[15], z_ff[14:0]};
   assign tprod   = {{(TIW + 1){1'b0}}, zu} * (17 + TIW)'(SIG_TABLE_DEPTH);
   assign ti      = tprod[15+TIW:16];
   assign sig_val = {3'b000, sig_rom[ti]};

   always_comb begin
      req_in       = cmd.take ? req_data : req_ff;
      gain_in      = gain_ff;
      lr_in        = lr_ff;
      facc_in      = facc_ff;
      bacc_in      = bacc_ff;
      oact_in      = oact_ff;
      lgrad_in     = lgrad_ff;
      prod_in      = cmd.mul_en ? mul_p : prod_ff;
      part_in      = cmd.lo_save ? prod_ff : part_ff;
      z_in         = cmd.z_load ? sat16w(zr) : z_ff;
      s_in         = cmd.s_load ? rs16({bacc_ff[39], bacc_ff}) : s_ff;
      p_in         = cmd.p_load ? pr[19:0] : p_ff;
      t_in         = cmd.t_load ? prod_rs : t_ff;
      wok_in       = wok_ff;
      aok_in       = aok_ff;
      wvld_in      = wvld_ff;
      avld_in      = avld_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN:       gain_in = csr_data;
            CSR_LEARN_RATE: lr_in   = csr_data[14:0];
            default: ;
         endcase
      end

      if (cmd.take) begin
         wok_in = in_ok && wvld_ff[in_addr];
         aok_in = in_ok && avld_ff[in_addr];
      end
      if (w_we) begin
         wvld_in[cur_addr] = 1'b1;
      end
      if (a_we) begin
         avld_in[cur_addr] = 1'b1;
      end

      if (cmd.acc_fwd) begin
         facc_in = sat40({facc_ff[39], facc_ff} + {prod_ff[39], prod_ff});
      end
      if (cmd.acc_bwd) begin
         bacc_in = sat40({bacc_ff[39], bacc_ff} + {prod_ff[39], prod_ff});
      end

      if (cmd.emit_act) begin
         oact_in             = sig_val;
         facc_in             = '0;
         rsp_in.kind         = KIND_ACT;
         rsp_in.result_value = sig_val;
         rsp_in.delta        = '0;
         rsp_in.slot         = '0;
         rsp_valid_in        = 1'b1;
      end
      if (cmd.emit_grad) begin
         lgrad_in            = prod_rs;
         bacc_in             = '0;
         rsp_in.kind         = KIND_GRAD;
         rsp_in.result_value = prod_rs;
         rsp_in.delta        = '0;
         rsp_in.slot         = '0;
         rsp_valid_in        = 1'b1;
      end
      if (cmd.emit_upd) begin
         rsp_in.kind         = KIND_UPD;
         rsp_in.result_value = new_w;
         rsp_in.delta        = prod_rs;
         rsp_in.slot         = req_ff.index;
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         lr_ff        <= LEARN_RATE_RESET;
         facc_ff      <= '0;
         bacc_ff      <= '0;
         oact_ff      <= '0;
         lgrad_ff     <= '0;
         wvld_ff      <= '0;
         avld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         lr_ff        <= lr_in;
         facc_ff      <= facc_in;
         bacc_ff      <= bacc_in;
         oact_ff      <= oact_in;
         lgrad_ff     <= lgrad_in;
         wvld_ff      <= wvld_in;
         avld_ff      <= avld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      prod_ff <= prod_in;
      part_ff <= part_in;
      z_ff    <= z_in;
      s_ff    <= s_in;
      p_ff    <= p_in;
      t_ff    <= t_in;
      wok_ff  <= wok_in;
      aok_ff  <= aok_in;
      rsp_ff  <= rsp_in;
   end

   assign status.last     = req_ff.last;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

@@ rtl/sigmoid_neuron_train_step.sv @@
`timescale 1ns / 1ps
// one transaction at a time; req_ready is high only while the sequencer is idle
// a load writes its weight; a forward or backward element multiplies then accumulates;
// the last element adds gain or gradient steps and a weight update multiplies twice, all
// on the single shared 18x22 multiplier and its registered product; the response
// shows on rsp_valid the cycle after the last step and is held in an output register
// synchronous reset: stores read as zero, accumulators cleared, gain 4096, learn rate 410

module sigmoid_neuron_train_step import snts_pkg::*; #(
   parameter int FANIN           = 16,
   parameter int SIG_TABLE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   cmd_type    cmd;
   status_type status;

   snts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_data.opcode),
      .status     (status),
      .cmd        (cmd)
   );

   snts_dp #(
      .FANIN           (FANIN),
      .SIG_TABLE_DEPTH (SIG_TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
